// ===== rtl/idb_pkg.sv =====
package idb_pkg;

  // Widths of the fixed port fields.
  localparam int unsigned COORD_W = 32;
  localparam int unsigned DIST_W  = 33;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [DIST_W-1:0]         dist_t;

  // One result beat as it sits in the output register or the skid register.
  typedef struct packed {
    dist_t lo;
    dist_t hi;
    logic  empty;
  } out_beat_t;

endpackage

// ===== rtl/interval_distance_bound_unit.sv =====
// Channel   Handshake                Payload
// in_       in_valid / in_ready      8 coordinates, bounds_finite, dist_in_low/high
// out_      out_valid / out_ready    dist_out_low/high, domain_empty
//
// One beat enters per cycle while the pipeline is not held. The stages are: difference,
// min/max, square and sum stages, one root bit per stage over COORD_WIDTH + 1
// stages, a rounding stage and the output register.
// Reset clears the valid bits only; data registers are not reset.
// An output register with one skid register parts the sides. When the output
// waits, the next finished beat drops into the skid register and the whole
// pipeline, input included, holds until the output takes the waiting beat.
module interval_distance_bound_unit #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  idb_pkg::coord_t in_ax_low,
  input  idb_pkg::coord_t in_ax_high,
  input  idb_pkg::coord_t in_ay_low,
  input  idb_pkg::coord_t in_ay_high,
  input  idb_pkg::coord_t in_bx_low,
  input  idb_pkg::coord_t in_bx_high,
  input  idb_pkg::coord_t in_by_low,
  input  idb_pkg::coord_t in_by_high,
  input  logic           in_bounds_finite,
  input  idb_pkg::dist_t in_dist_in_low,
  input  idb_pkg::dist_t in_dist_in_high,
  output logic           out_valid,
  input  logic           out_ready,
  output idb_pkg::dist_t out_dist_out_low,
  output idb_pkg::dist_t out_dist_out_high,
  output logic           out_domain_empty
);
  import idb_pkg::*;

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned RW  = CW + 1;      // root width
  localparam int unsigned SW  = 2 * RW;      // radicand width, even
  localparam int unsigned RMW = RW + 2;      // partial remainder width
  localparam int unsigned NSQ = RW;          // root stages

  typedef logic [CW-1:0] mag_t;

  // Absolute difference of two signed coordinates; fits in CW bits.
  function automatic mag_t abs_diff(input mag_t a, input mag_t b);
    logic signed [CW:0] d;
    logic signed [CW:0] n;
    d = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    n = -d;
    abs_diff = d[CW] ? n[CW-1:0] : d[CW-1:0];
  endfunction

  function automatic logic sle(input mag_t a, input mag_t b);
    sle = $signed(a) <= $signed(b);
  endfunction

  logic pipe_en;
  logic skid_v_r;

  assign pipe_en  = !skid_v_r;
  assign in_ready = pipe_en;

  // Stage 1: corner differences and interval overlap tests.
  mag_t ax_l, ax_h, ay_l, ay_h, bx_l, bx_h, by_l, by_h;
  assign ax_l = in_ax_low[CW-1:0];
  assign ax_h = in_ax_high[CW-1:0];
  assign ay_l = in_ay_low[CW-1:0];
  assign ay_h = in_ay_high[CW-1:0];
  assign bx_l = in_bx_low[CW-1:0];
  assign bx_h = in_bx_high[CW-1:0];
  assign by_l = in_by_low[CW-1:0];
  assign by_h = in_by_high[CW-1:0];

  logic  s1_v_r;
  mag_t  s1_dx_r [4];
  mag_t  s1_dy_r [4];
  logic  s1_ovx_r, s1_ovy_r, s1_fin_r;
  dist_t s1_dl_r, s1_dh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (pipe_en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_dx_r[0] <= abs_diff(ax_l, bx_l);
      s1_dx_r[1] <= abs_diff(ax_l, bx_h);
      s1_dx_r[2] <= abs_diff(ax_h, bx_l);
      s1_dx_r[3] <= abs_diff(ax_h, bx_h);
      s1_dy_r[0] <= abs_diff(ay_l, by_l);
      s1_dy_r[1] <= abs_diff(ay_l, by_h);
      s1_dy_r[2] <= abs_diff(ay_h, by_l);
      s1_dy_r[3] <= abs_diff(ay_h, by_h);
      // max(lows) <= min(highs) holds when every low is at most every high.
      s1_ovx_r   <= sle(ax_l, ax_h) && sle(ax_l, bx_h) && sle(bx_l, ax_h) && sle(bx_l, bx_h);
      s1_ovy_r   <= sle(ay_l, ay_h) && sle(ay_l, by_h) && sle(by_l, ay_h) && sle(by_l, by_h);
      s1_fin_r   <= in_bounds_finite;
      s1_dl_r    <= in_dist_in_low;
      s1_dh_r    <= in_dist_in_high;
    end
  end

  // Stage 2: minimum and maximum per axis, minimum forced to zero on overlap.
  mag_t xmn_a, xmn_b, xmx_a, xmx_b, ymn_a, ymn_b, ymx_a, ymx_b;
  assign xmn_a = (s1_dx_r[1] < s1_dx_r[0]) ? s1_dx_r[1] : s1_dx_r[0];
  assign xmn_b = (s1_dx_r[3] < s1_dx_r[2]) ? s1_dx_r[3] : s1_dx_r[2];
  assign xmx_a = (s1_dx_r[1] > s1_dx_r[0]) ? s1_dx_r[1] : s1_dx_r[0];
  assign xmx_b = (s1_dx_r[3] > s1_dx_r[2]) ? s1_dx_r[3] : s1_dx_r[2];
  assign ymn_a = (s1_dy_r[1] < s1_dy_r[0]) ? s1_dy_r[1] : s1_dy_r[0];
  assign ymn_b = (s1_dy_r[3] < s1_dy_r[2]) ? s1_dy_r[3] : s1_dy_r[2];
  assign ymx_a = (s1_dy_r[1] > s1_dy_r[0]) ? s1_dy_r[1] : s1_dy_r[0];
  assign ymx_b = (s1_dy_r[3] > s1_dy_r[2]) ? s1_dy_r[3] : s1_dy_r[2];

  logic  s2_v_r, s2_fin_r;
  mag_t  s2_dxl_r, s2_dxh_r, s2_dyl_r, s2_dyh_r;
  dist_t s2_dl_r, s2_dh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (pipe_en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s2_dxl_r <= s1_ovx_r ? '0 : ((xmn_b < xmn_a) ? xmn_b : xmn_a);
      s2_dxh_r <= (xmx_b > xmx_a) ? xmx_b : xmx_a;
      s2_dyl_r <= s1_ovy_r ? '0 : ((ymn_b < ymn_a) ? ymn_b : ymn_a);
      s2_dyh_r <= (ymx_b > ymx_a) ? ymx_b : ymx_a;
      s2_fin_r <= s1_fin_r;
      s2_dl_r  <= s1_dl_r;
      s2_dh_r  <= s1_dh_r;
    end
  end

  // Stage 3: the four squares.
  logic [2*CW-1:0] sq_xl, sq_xh, sq_yl, sq_yh;
  assign sq_xl = {{CW{1'b0}}, s2_dxl_r} * {{CW{1'b0}}, s2_dxl_r};
  assign sq_xh = {{CW{1'b0}}, s2_dxh_r} * {{CW{1'b0}}, s2_dxh_r};
  assign sq_yl = {{CW{1'b0}}, s2_dyl_r} * {{CW{1'b0}}, s2_dyl_r};
  assign sq_yh = {{CW{1'b0}}, s2_dyh_r} * {{CW{1'b0}}, s2_dyh_r};

  logic            s3_v_r, s3_fin_r;
  logic [2*CW-1:0] s3_xl_r, s3_xh_r, s3_yl_r, s3_yh_r;
  dist_t           s3_dl_r, s3_dh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (pipe_en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s3_xl_r  <= sq_xl;
      s3_xh_r  <= sq_xh;
      s3_yl_r  <= sq_yl;
      s3_yh_r  <= sq_yh;
      s3_fin_r <= s2_fin_r;
      s3_dl_r  <= s2_dl_r;
      s3_dh_r  <= s2_dh_r;
    end
  end

  // Stage 4: sums of squares, the radicands of the two roots.
  logic          s4_v_r, s4_fin_r;
  logic [SW-1:0] s4_rlo_r, s4_rhi_r;
  dist_t         s4_dl_r, s4_dh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (pipe_en) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s4_rlo_r <= SW'(s3_xl_r) + SW'(s3_yl_r);
      s4_rhi_r <= SW'(s3_xh_r) + SW'(s3_yh_r);
      s4_fin_r <= s3_fin_r;
      s4_dl_r  <= s3_dl_r;
      s4_dh_r  <= s3_dh_r;
    end
  end

  // Root stages: one result bit per stage, digit by digit from the top pair
  // of radicand bits, with the partial remainder carried along.
  logic            sq_v_r   [NSQ];
  logic            sq_fin_r [NSQ];
  dist_t           sq_dl_r  [NSQ];
  dist_t           sq_dh_r  [NSQ];
  logic [RW-1:0]   rt_lo_r  [NSQ];
  logic [RW-1:0]   rt_hi_r  [NSQ];
  logic [RMW-1:0]  rm_lo_r  [NSQ];
  logic [RMW-1:0]  rm_hi_r  [NSQ];
  logic [SW-1:0]   rd_lo_r  [NSQ-1];
  logic [SW-1:0]   rd_hi_r  [NSQ-1];

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    logic           v_in, fin_in;
    dist_t          dl_in, dh_in;
    logic [RW-1:0]  rt_lo_in, rt_hi_in;
    logic [RMW-1:0] rm_lo_in, rm_hi_in;
    logic [SW-1:0]  rd_lo_in, rd_hi_in;
    logic [RMW-1:0] sh_lo, sh_hi, tr_lo, tr_hi;
    logic           ge_lo, ge_hi;

    if (k == 0) begin : g_first
      assign v_in     = s4_v_r;
      assign fin_in   = s4_fin_r;
      assign dl_in    = s4_dl_r;
      assign dh_in    = s4_dh_r;
      assign rt_lo_in = '0;
      assign rt_hi_in = '0;
      assign rm_lo_in = '0;
      assign rm_hi_in = '0;
      assign rd_lo_in = s4_rlo_r;
      assign rd_hi_in = s4_rhi_r;
    end else begin : g_next
      assign v_in     = sq_v_r[k-1];
      assign fin_in   = sq_fin_r[k-1];
      assign dl_in    = sq_dl_r[k-1];
      assign dh_in    = sq_dh_r[k-1];
      assign rt_lo_in = rt_lo_r[k-1];
      assign rt_hi_in = rt_hi_r[k-1];
      assign rm_lo_in = rm_lo_r[k-1];
      assign rm_hi_in = rm_hi_r[k-1];
      assign rd_lo_in = rd_lo_r[k-1];
      assign rd_hi_in = rd_hi_r[k-1];
    end

    // Bring down the next bit pair and try root*4+1 against it.
    assign sh_lo = {rm_lo_in[RMW-3:0], rd_lo_in[SW-1-2*k -: 2]};
    assign sh_hi = {rm_hi_in[RMW-3:0], rd_hi_in[SW-1-2*k -: 2]};
    assign tr_lo = {rt_lo_in, 2'b01};
    assign tr_hi = {rt_hi_in, 2'b01};
    assign ge_lo = sh_lo >= tr_lo;
    assign ge_hi = sh_hi >= tr_hi;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k] <= 1'b0;
      end else if (pipe_en) begin
        sq_v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        sq_fin_r[k] <= fin_in;
        sq_dl_r[k]  <= dl_in;
        sq_dh_r[k]  <= dh_in;
        rt_lo_r[k]  <= {rt_lo_in[RW-2:0], ge_lo};
        rt_hi_r[k]  <= {rt_hi_in[RW-2:0], ge_hi};
        rm_lo_r[k]  <= ge_lo ? (sh_lo - tr_lo) : sh_lo;
        rm_hi_r[k]  <= ge_hi ? (sh_hi - tr_hi) : sh_hi;
      end
    end

    // The radicand is no longer needed after the last stage.
    if (k < NSQ - 1) begin : g_rad
      always_ff @(posedge clk) begin
        if (pipe_en) begin
          rd_lo_r[k] <= rd_lo_in;
          rd_hi_r[k] <= rd_hi_in;
        end
      end
    end
  end

  // Rounding stage: ceiling of the upper root, raised lower bound.
  logic [RW:0] ceil_hi;
  dist_t       cand_lo, cand_hi, last_dl;
  logic        last_fin;

  assign last_fin = sq_fin_r[NSQ-1];
  assign last_dl  = sq_dl_r[NSQ-1];
  assign ceil_hi  = {1'b0, rt_hi_r[NSQ-1]} + {{RW{1'b0}}, |rm_hi_r[NSQ-1]};
  assign cand_lo  = dist_t'(rt_lo_r[NSQ-1]);
  assign cand_hi  = dist_t'(ceil_hi);

  logic  f_v_r, f_fin_r;
  dist_t f_lo_r, f_ch_r, f_dh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (pipe_en) begin
      f_v_r <= sq_v_r[NSQ-1];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      f_lo_r  <= (last_fin && (cand_lo > last_dl)) ? cand_lo : last_dl;
      f_ch_r  <= cand_hi;
      f_dh_r  <= sq_dh_r[NSQ-1];
      f_fin_r <= last_fin;
    end
  end

  // Upper bound and empty flag; the flag compares against both inputs of
  // the minimum so the two compares run side by side.
  out_beat_t tail_beat;

  assign tail_beat.lo    = f_lo_r;
  assign tail_beat.hi    = (f_fin_r && (f_ch_r < f_dh_r)) ? f_ch_r : f_dh_r;
  assign tail_beat.empty = (f_lo_r > f_dh_r) || (f_fin_r && (f_lo_r > f_ch_r));

  // Output register with one skid register behind it.
  logic      out_v_r;
  out_beat_t out_beat_r, skid_beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_ready) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (!out_v_r || out_ready) begin
      out_v_r <= f_v_r;
    end else if (f_v_r) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_ready) begin
        out_beat_r <= skid_beat_r;
      end
    end else if (!out_v_r || out_ready) begin
      out_beat_r <= tail_beat;
    end else if (f_v_r) begin
      skid_beat_r <= tail_beat;
    end
  end

  assign out_valid         = out_v_r;
  assign out_dist_out_low  = out_beat_r.lo;
  assign out_dist_out_high = out_beat_r.hi;
  assign out_domain_empty  = out_beat_r.empty;

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  import idb_pkg::*;

  // One input beat: two uncertain points and the current distance interval.
  typedef struct packed {
    coord_t ax_lo;
    coord_t ax_hi;
    coord_t ay_lo;
    coord_t ay_hi;
    coord_t bx_lo;
    coord_t bx_hi;
    coord_t by_lo;
    coord_t by_hi;
    logic   finite;
    dist_t  dist_lo;
    dist_t  dist_hi;
  } point_pair_t;

  localparam int unsigned PIPE_LATENCY = COORD_W + 7;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam coord_t      CMIN         = 32'sh8000_0000;
  localparam coord_t      CMAX         = 32'sh7fff_ffff;
  localparam dist_t       DIST_MAX     = '1;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  coord_t in_ax_low = '0;
  coord_t in_ax_high = '0;
  coord_t in_ay_low = '0;
  coord_t in_ay_high = '0;
  coord_t in_bx_low = '0;
  coord_t in_bx_high = '0;
  coord_t in_by_low = '0;
  coord_t in_by_high = '0;
  logic   in_bounds_finite = 1'b0;
  dist_t  in_dist_in_low = '0;
  dist_t  in_dist_in_high = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  dist_t  out_dist_out_low;
  dist_t  out_dist_out_high;
  logic   out_domain_empty;

  // Predicted results, oldest first.
  out_beat_t pending_bounds[$];
  out_beat_t want_beat;

  logic        idle_off = 1'b0;
  int unsigned errors = 0;
  int unsigned beats_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned unbounded_beats = 0;
  int unsigned empty_beats = 0;
  int unsigned stall_cycles = 0;
  int unsigned coord_mags[5] = '{4, 12, 20, 31, 32};

  interval_distance_bound_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_ax_low        (in_ax_low),
    .in_ax_high       (in_ax_high),
    .in_ay_low        (in_ay_low),
    .in_ay_high       (in_ay_high),
    .in_bx_low        (in_bx_low),
    .in_bx_high       (in_bx_high),
    .in_by_low        (in_by_low),
    .in_by_high       (in_by_high),
    .in_bounds_finite (in_bounds_finite),
    .in_dist_in_low   (in_dist_in_low),
    .in_dist_in_high  (in_dist_in_high),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_dist_out_low (out_dist_out_low),
    .out_dist_out_high(out_dist_out_high),
    .out_domain_empty (out_domain_empty)
  );

  always #10 clk = ~clk;

  // Absolute difference of two coordinates; at most 2^32 - 1.
  function automatic logic [32:0] coord_gap(input coord_t a, input coord_t b);
    logic signed [33:0] d;
    d = a - b;
    if (d < 0) d = -d;
    return d[32:0];
  endfunction

  // Range of |delta| on one axis, with the minimum forced to 0 on overlap.
  function automatic void axis_range(input coord_t l1, input coord_t h1,
                                     input coord_t l2, input coord_t h2,
                                     output logic [32:0] lo,
                                     output logic [32:0] hi);
    logic [32:0] d[4];
    coord_t      max_lo;
    coord_t      min_hi;
    d[0] = coord_gap(l1, l2);
    d[1] = coord_gap(l1, h2);
    d[2] = coord_gap(h1, l2);
    d[3] = coord_gap(h1, h2);
    lo = d[0];
    hi = d[0];
    for (int i = 1; i < 4; i++) begin
      if (d[i] < lo) lo = d[i];
      if (d[i] > hi) hi = d[i];
    end
    max_lo = (l1 > l2) ? l1 : l2;
    min_hi = (h1 < h2) ? h1 : h2;
    if (max_lo <= min_hi) lo = '0;
  endfunction

  // Exact floor or ceiling of sqrt(a^2 + b^2), one root bit at a time.
  function automatic logic [34:0] hypot_root(input logic [32:0] a, input logic [32:0] b,
                                             input logic round_up);
    logic [67:0] sum;
    logic [69:0] sq;
    logic [34:0] r;
    logic [34:0] cand;
    sum = a * a + b * b;
    r = '0;
    for (int bit_pos = 34; bit_pos >= 0; bit_pos--) begin
      cand = r | (35'd1 << bit_pos);
      sq = cand * cand;
      if (sq <= sum) r = cand;
    end
    sq = r * r;
    if (round_up && sq < sum) r = r + 1'b1;
    return r;
  endfunction

  // Narrowed distance interval for one beat.
  function automatic out_beat_t predict_bounds(input point_pair_t p);
    out_beat_t   res;
    logic [32:0] dx_lo, dx_hi, dy_lo, dy_hi;
    logic [34:0] lo, hi, cand_lo, cand_hi;
    lo = p.dist_lo;
    hi = p.dist_hi;
    if (p.finite) begin
      axis_range(p.ax_lo, p.ax_hi, p.bx_lo, p.bx_hi, dx_lo, dx_hi);
      axis_range(p.ay_lo, p.ay_hi, p.by_lo, p.by_hi, dy_lo, dy_hi);
      cand_lo = hypot_root(dx_lo, dy_lo, 1'b0);
      cand_hi = hypot_root(dx_hi, dy_hi, 1'b1);
      if (cand_lo > lo) lo = cand_lo;
      if (cand_hi < hi) hi = cand_hi;
    end
    res.lo = lo[32:0];
    res.hi = hi[32:0];
    res.empty = (lo > hi);
    return res;
  endfunction

  function automatic point_pair_t make_pair(input coord_t axl, input coord_t axh,
                                            input coord_t ayl, input coord_t ayh,
                                            input coord_t bxl, input coord_t bxh,
                                            input coord_t byl, input coord_t byh,
                                            input logic fin, input dist_t dl,
                                            input dist_t dh);
    point_pair_t p;
    p.ax_lo = axl;
    p.ax_hi = axh;
    p.ay_lo = ayl;
    p.ay_hi = ayh;
    p.bx_lo = bxl;
    p.bx_hi = bxh;
    p.by_lo = byl;
    p.by_hi = byh;
    p.finite = fin;
    p.dist_lo = dl;
    p.dist_hi = dh;
    return p;
  endfunction

  // Signed value of m bits, sign-extended to the coordinate width.
  function automatic coord_t rand_coord(input int unsigned m);
    coord_t v;
    v = $urandom;
    return v >>> (32 - m);
  endfunction

  // Well-formed interval; a quarter of them are only a few units wide.
  function automatic void rand_interval(input int unsigned m, output coord_t lo,
                                        output coord_t hi);
    coord_t a, b;
    a = rand_coord(m);
    if ($urandom_range(3, 0) == 0) b = {a[31:4], 4'($urandom)};
    else b = rand_coord(m);
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
  endfunction

  function automatic point_pair_t random_pair();
    point_pair_t p;
    out_beat_t   cand;
    int unsigned m;
    coord_t      l0, l1, l2, l3, h0, h1, h2, h3;
    m = coord_mags[$urandom_range(4, 0)];
    if ($urandom_range(99, 0) < 15) begin
      // Noise: any coordinate order, inverted intervals included.
      p = make_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, 1'b1, '0, '0);
    end else begin
      rand_interval(m, l0, h0);
      rand_interval(m, l1, h1);
      rand_interval(m, l2, h2);
      rand_interval(m, l3, h3);
      p = make_pair(l0, h0, l1, h1, l2, h2, l3, h3, 1'b1, '0, '0);
    end
    case ($urandom_range(3, 0))
      0: begin
        p.dist_lo = dist_t'({$urandom, $urandom});
        p.dist_hi = dist_t'({$urandom, $urandom});
      end
      3: begin
        p.dist_lo = $urandom_range(1, 0) ? DIST_MAX : '0;
        p.dist_hi = $urandom_range(1, 0) ? DIST_MAX : '0;
      end
      default: begin
        // Land the current interval close to the candidate so both cuts matter.
        p.dist_hi = DIST_MAX;
        cand = predict_bounds(p);
        p.dist_lo = cand.lo + dist_t'($urandom_range(4, 0)) - dist_t'($urandom_range(4, 0));
        p.dist_hi = cand.hi + dist_t'($urandom_range(4, 0)) - dist_t'($urandom_range(4, 0));
      end
    endcase
    p.finite = ($urandom_range(9, 0) != 0);
    return p;
  endfunction

  // Drive one beat, hold it until accepted, and record its prediction.
  task automatic send_item(input point_pair_t p);
    out_beat_t predicted;
    if (!idle_off && $urandom_range(99, 0) < 21) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < 40);
    end
    in_valid         <= 1'b1;
    in_ax_low        <= p.ax_lo;
    in_ax_high       <= p.ax_hi;
    in_ay_low        <= p.ay_lo;
    in_ay_high       <= p.ay_hi;
    in_bx_low        <= p.bx_lo;
    in_bx_high       <= p.bx_hi;
    in_by_low        <= p.by_lo;
    in_by_high       <= p.by_hi;
    in_bounds_finite <= p.finite;
    in_dist_in_low   <= p.dist_lo;
    in_dist_in_high  <= p.dist_hi;
    do @(posedge clk); while (!in_ready);
    predicted = predict_bounds(p);
    pending_bounds.push_back(predicted);
    beats_sent++;
    if (!p.finite) unbounded_beats++;
    if (predicted.empty) empty_beats++;
  endtask

  // Lower valid and wait until every predicted result has been seen.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_bounds.size() != 0);
  endtask

  // Field extremes and each special case of the interval logic.
  task automatic test_directed_corners();
    send_item(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 1'b1, '0, DIST_MAX));
    send_item(make_pair(CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, 1'b1, '0, DIST_MAX));
    send_item(make_pair(CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, 1'b1,
                        DIST_MAX, DIST_MAX));
    send_item(make_pair(CMIN, CMAX, 0, 0, CMIN, CMAX, 0, 0, 1'b1, '0, DIST_MAX));
    send_item(make_pair(CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, CMIN, CMAX, 1'b1, '0, DIST_MAX));
    // Overlapping intervals on both axes pull the lower root candidate to zero.
    send_item(make_pair(-100, 100, -100, 100, 50, 200, 50, 200, 1'b1, 33'd7, DIST_MAX));
    // Exact and inexact roots.
    send_item(make_pair(0, 0, 0, 0, 3, 3, 4, 4, 1'b1, '0, DIST_MAX));
    send_item(make_pair(0, 0, 0, 0, 1, 1, 1, 1, 1'b1, '0, DIST_MAX));
    // Bounds not finite: the distance interval passes through.
    send_item(make_pair(CMIN, CMAX, CMIN, CMAX, 0, 0, 0, 0, 1'b0, 33'd5, 33'd3));
    send_item(make_pair(0, 0, 0, 0, 9, 9, 9, 9, 1'b0, 33'd3, 33'd5));
    send_item(make_pair(-1, -1, -1, -1, -1, -1, -1, -1, 1'b0, DIST_MAX, DIST_MAX));
    // Inverted coordinate intervals; neither counts as overlapping on x.
    send_item(make_pair(10, -10, 0, 0, 0, 0, 0, 0, 1'b1, '0, DIST_MAX));
    send_item(make_pair(100, 50, 0, 0, 60, 70, 0, 0, 1'b1, '0, DIST_MAX));
    // Inverted and disjoint distance intervals.
    send_item(make_pair(0, 0, 0, 0, 3, 3, 4, 4, 1'b1, 33'd1000, 33'd10));
    send_item(make_pair(0, 0, 0, 0, 3, 3, 4, 4, 1'b1, 33'd1000, 33'd2000));
    send_item(make_pair(CMIN, CMIN, 0, 0, CMAX, CMAX, 0, 0, 1'b1, '0, '0));
    send_item(make_pair(-1, -1, -1, -1, -1, -1, -1, -1, 1'b1, DIST_MAX, DIST_MAX));
  endtask

  task automatic test_random_geometry(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_item(random_pair());
  endtask

  // Bursts separated by full pauses in which the pipeline empties.
  task automatic test_drain_pause();
    for (int unsigned round = 0; round < 3; round++) begin
      for (int unsigned i = 0; i < 40; i++) send_item(random_pair());
      wait_for_drain();
    end
  endtask

  // Full rate on both sides, then back to random stalls.
  task automatic test_back_to_back(input int unsigned count);
    idle_off = 1'b1;
    for (int unsigned i = 0; i < count; i++) send_item(random_pair());
    idle_off = 1'b0;
  endtask

  // Receiver stalls at random unless idling is switched off.
  always @(posedge clk) begin
    out_ready <= idle_off || ($urandom_range(99, 0) >= 21);
  end

  // Compare each result beat with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_bounds.size() == 0) begin
        errors++;
        $display("%0t: result beat with no prediction waiting: low %0d high %0d empty %0b",
                 $time, out_dist_out_low, out_dist_out_high, out_domain_empty);
      end else begin
        want_beat = pending_bounds.pop_front();
        beats_checked++;
        if (out_dist_out_low !== want_beat.lo) begin
          errors++;
          $display("%0t: dist_out_low expected %0d, got %0d",
                   $time, want_beat.lo, out_dist_out_low);
        end
        if (out_dist_out_high !== want_beat.hi) begin
          errors++;
          $display("%0t: dist_out_high expected %0d, got %0d",
                   $time, want_beat.hi, out_dist_out_high);
        end
        if (out_domain_empty !== want_beat.empty) begin
          errors++;
          $display("%0t: domain_empty expected %0b, got %0b",
                   $time, want_beat.empty, out_domain_empty);
        end
      end
    end
  end

  // End the run if no beat moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, pending_bounds.size());
      $display("FAIL interval_distance_bound_unit");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_corners();
    test_random_geometry(550);
    test_drain_pause();
    test_back_to_back(350);
    test_random_geometry(20);
    wait_for_drain();
    // Catch any stray beat that follows the last expected one.
    repeat (PIPE_LATENCY + 10) @(posedge clk);
    $display("Sent %0d beats (%0d with unbounded coordinates, %0d predicted empty);",
             beats_sent, unbounded_beats, empty_beats);
    $display("checked %0d results across stalled, drained and full-rate traffic.",
             beats_checked);
    if (errors == 0) begin
      $display("PASS interval_distance_bound_unit");
    end else begin
      $display("FAIL interval_distance_bound_unit");
    end
    $finish;
  end

endmodule
